FILE: rtl/core/sst_pkg.sv
// Shared constants, codes and cell control type for the sorted set table.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W = 32;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_ABSENT = 2'd2;

  typedef struct packed {
    logic                    cmp;
    logic                    ins;
    logic                    rem;
    logic signed [VAL_W-1:0] key;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/sst_cell.sv
// One table slot: holds an entry, compares it with the key and shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module sst_cell import sst_pkg::*; (
  input  logic                    clk_i,
  input  cell_cmd_t               cmd_i,
  input  logic                    valid_i,
  input  logic signed [VAL_W-1:0] left_key_i,
  input  logic                    left_gt_i,
  input  logic signed [VAL_W-1:0] right_key_i,
  output logic signed [VAL_W-1:0] key_o,
  output logic                    gt_o,
  output logic                    eq_o
);

  logic signed [VAL_W-1:0] entry_q, entry_d;
  logic                    gt_q, ge_q, eq_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins && gt_q) begin
      entry_d = left_gt_i ? left_key_i : cmd_i.key;
    end else if (cmd_i.rem && ge_q) begin
      entry_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (cmd_i.cmp) begin
      gt_q <= !valid_i || (entry_q > cmd_i.key);
      ge_q <= !valid_i || (entry_q >= cmd_i.key);
      eq_q <= valid_i && (entry_q == cmd_i.key);
    end
  end

  assign key_o = entry_q;
  assign gt_o  = gt_q;
  assign eq_o  = eq_q;

endmodule

`default_nettype wire

FILE: rtl/core/sorted_set_table.sv
// Top level of the sorted set table: sequencer, entry count, cell row and result register.
// The table holds up to DEPTH signed 32-bit values in ascending order in a row of cells,
// one value per cell. Each transfer on the input carries a mode (insert, remove, lookup;
// the unused code acts as a lookup) and a value, and gives exactly one result: found,
// status and the entry count after the operation. Each item has a compare step, in which
// every cell compares its entry with the key at once, and an update step, in which every
// cell loads from itself or a neighbour and the result register is loaded. A new item is
// taken while idle or in the update step of the item before, if the result register can
// drain. The result register holds a result until it is taken; while it is full and not
// taken the update waits. Insert into a full table reports status 1, remove of an absent
// value reports status 2, and neither changes the table. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_table import sst_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              mode_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    found_o,
  output logic [1:0]              status_o,
  output logic [CNT_W-1:0]        entry_count_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [1:0]              mode_q;
  logic signed [VAL_W-1:0] key_q;
  logic                    out_valid_q;
  logic                    found_q, found_d;
  logic [1:0]              status_q, status_d;

  logic                    can_load, accept, update;
  logic                    hit, full, do_ins, do_rem;
  cell_cmd_t               cmd;

  logic [DEPTH-1:0]              valid;
  logic [DEPTH-1:0]              gt, eq;
  logic signed [VAL_W-1:0]       keys [DEPTH];

  assign can_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_UPD) && can_load);
  assign accept     = in_valid_i && in_ready_o;
  assign update     = (state_q == S_UPD) && can_load;

  assign hit    = |eq;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign do_ins = update && (mode_q == MODE_INSERT) && !full;
  assign do_rem = update && (mode_q == MODE_REMOVE) && hit;

  assign cmd.cmp = (state_q == S_CMP);
  assign cmd.ins = do_ins;
  assign cmd.rem = do_rem;
  assign cmd.key = key_q;

  always_comb begin
    found_d  = hit;
    status_d = STATUS_OK;
    count_d  = count_q;
    case (mode_q)
      MODE_INSERT: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (!hit) begin
          status_d = STATUS_ABSENT;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CMP;
      S_CMP:   state_d = S_UPD;
      S_UPD:   if (can_load) state_d = in_valid_i ? S_CMP : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (update) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      key_q  <= value_i;
    end
    if (update) begin
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_key, right_key;
    logic                    left_gt;

    assign valid[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_key = key_q;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_key = keys[i-1];
      assign left_gt  = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_inner
      assign right_key = keys[i+1];
    end

    sst_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .valid_i     (valid[i]),
      .left_key_i  (left_key),
      .left_gt_i   (left_gt),
      .right_key_i (right_key),
      .key_o       (keys[i]),
      .gt_o        (gt[i]),
      .eq_o        (eq[i])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_no_take_in_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> !in_ready_o)
    else $error("input taken during compare cycle");

  a_upd_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_UPD) && !can_load) |=> ((state_q == S_UPD) && $stable(count_q)))
    else $error("update went ahead while result register full");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    update |=> ((count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1))
                || (count_q == $past(count_q) - CNT_W'(1))))
    else $error("entry count moved by more than one");
`endif

endmodule

`default_nettype wire
